FILE: rtl/core/ntss_pkg.sv
// ----------------------------------------------------------------------------
// ntss_pkg
// Shared types, constants and the segment table for the number to
// seven-segment write unit.
// ----------------------------------------------------------------------------
package ntss_pkg;

  localparam int DIGIT_COUNT = 8;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 3;
  localparam int DIGIT_W     = 4;
  localparam int ADDR_W      = 4;
  localparam int SEG_W       = 7;

  localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int                 RECIP_SHIFT = 35;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] rest;
    logic               hex;
    logic [POS_W-1:0]   pos;
  } ntss_cell_t;

  typedef struct packed {
    logic               valid;
    logic [DIGIT_W-1:0] digit;
    logic [POS_W-1:0]   pos;
  } ntss_emit_t;

  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] seg;
    unique case (digit)
      4'h0: seg = 7'h3F;
      4'h1: seg = 7'h06;
      4'h2: seg = 7'h5B;
      4'h3: seg = 7'h4F;
      4'h4: seg = 7'h66;
      4'h5: seg = 7'h6D;
      4'h6: seg = 7'h7D;
      4'h7: seg = 7'h07;
      4'h8: seg = 7'h7F;
      4'h9: seg = 7'h6F;
      4'hA: seg = 7'h77;
      4'hB: seg = 7'h7C;
      4'hC: seg = 7'h39;
      4'hD: seg = 7'h5E;
      4'hE: seg = 7'h79;
      4'hF: seg = 7'h71;
    endcase
    return seg;
  endfunction

endpackage

FILE: rtl/core/ntss_if.sv
// ----------------------------------------------------------------------------
// ntss_if
// Valid/ready channels for the value word and the display write word.
// ----------------------------------------------------------------------------
interface ntss_in_if;
  logic                          valid;
  logic                          ready;
  logic [ntss_pkg::VALUE_W-1:0]  value;
  logic                          hex_mode;

  modport source (output valid, value, hex_mode, input ready);
  modport sink   (input valid, value, hex_mode, output ready);
endinterface

interface ntss_out_if;
  logic                          valid;
  logic                          ready;
  logic [ntss_pkg::ADDR_W-1:0]   ram_address;
  logic [ntss_pkg::SEG_W-1:0]    segments;
  logic                          is_last;

  modport source (output valid, ram_address, segments, is_last, input ready);
  modport sink   (input valid, ram_address, segments, is_last, output ready);
endinterface

FILE: rtl/core/number_to_seven_segment_writes_unit.sv
// ----------------------------------------------------------------------------
// number_to_seven_segment_writes_unit
// Turns a 32-bit value into DIGIT_COUNT display RAM writes, rightmost digit
// first, through a chain of digit cells.
// ----------------------------------------------------------------------------
// First write word: value buffer, then cell 0, then the output register.
// Throughput: one write word a cycle unless out_ch.ready stalls it, set by
//   the single output port; the wave walks the cell chain one cell a cycle
//   and the next word enters cell 0 as the last cell drains.
// Reset: synchronous active-low rst_n clears buffer, cell and output valids.
// ----------------------------------------------------------------------------
module number_to_seven_segment_writes_unit (
  input  logic clk,
  input  logic rst_n,
  ntss_in_if.sink    in_ch,
  ntss_out_if.source out_ch
);
  import ntss_pkg::*;

  logic               ibuf_valid_r;
  logic               ibuf_valid_nxt;
  logic [VALUE_W-1:0] ibuf_value_r;
  logic               ibuf_hex_r;

  logic               out_valid_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [SEG_W-1:0]   out_seg_r;
  logic               out_last_r;

  logic               adv;
  logic               busy;
  logic               load;
  logic               in_take;
  logic [DIGIT_W-1:0] sel_digit;
  logic [POS_W-1:0]   sel_pos;
  logic [DIGIT_COUNT-1:0] cell_valid;

  ntss_cell_t link [DIGIT_COUNT+1];
  ntss_emit_t emit [DIGIT_COUNT];

  assign adv     = !out_valid_r || out_ch.ready;
  assign busy    = |cell_valid;
  assign load    = adv && ibuf_valid_r && (!busy || link[DIGIT_COUNT].valid);
  assign in_take = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !ibuf_valid_r;

  always_comb begin
    ibuf_valid_nxt = ibuf_valid_r;
    priority if (load) begin
      ibuf_valid_nxt = 1'b0;
    end else if (in_take) begin
      ibuf_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ibuf_valid_r <= 1'b0;
    end else begin
      ibuf_valid_r <= ibuf_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ibuf_value_r <= in_ch.value;
      ibuf_hex_r   <= in_ch.hex_mode;
    end
  end

  always_comb begin
    link[0].valid = load;
    link[0].rest  = ibuf_value_r;
    link[0].hex   = ibuf_hex_r;
    link[0].pos   = POS_W'(DIGIT_COUNT - 1);
  end

  for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_cell
    ntss_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_in  (link[k]),
      .cell_out (link[k+1]),
      .emit     (emit[k])
    );
    assign cell_valid[k] = emit[k].valid;
  end

  always_comb begin
    sel_digit = '0;
    sel_pos   = '0;
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      sel_digit = sel_digit | (emit[k].digit & {DIGIT_W{emit[k].valid}});
      sel_pos   = sel_pos   | (emit[k].pos   & {POS_W{emit[k].valid}});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_addr_r <= {sel_pos, 1'b0};
      out_seg_r  <= seg_of(sel_digit);
      out_last_r <= (sel_pos == '0);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.ram_address = out_addr_r;
  assign out_ch.segments    = out_seg_r;
  assign out_ch.is_last     = out_last_r;

`ifndef ASSERT_OFF
  a_one_wave: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_valid))
    else $error("more than one cell holds a digit");

  a_load_enters: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> cell_valid[0])
    else $error("loaded word missing from first cell");

  a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && cell_valid[DIGIT_COUNT-1]) |=> (out_valid_r && out_last_r))
    else $error("last cell did not produce the final write");

  a_buf_load: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> ibuf_valid_r && !in_take)
    else $error("load without buffered word");
`endif

endmodule

FILE: rtl/core/ntss_cell.sv
// ----------------------------------------------------------------------------
// ntss_cell
// One digit cell: holds the remaining value, peels off one digit and hands
// the quotient to the next cell.
// ----------------------------------------------------------------------------
module ntss_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  ntss_pkg::ntss_cell_t cell_in,
  output ntss_pkg::ntss_cell_t cell_out,
  output ntss_pkg::ntss_emit_t emit
);
  import ntss_pkg::*;

  logic                 valid_r;
  logic [VALUE_W-1:0]   rest_r;
  logic                 hex_r;
  logic [POS_W-1:0]     pos_r;

  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quot;
  logic [DIGIT_W-1:0]   rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= cell_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rest_r <= cell_in.rest;
      hex_r  <= cell_in.hex;
      pos_r  <= cell_in.pos;
    end
  end

  always_comb begin
    prod = {{VALUE_W{1'b0}}, rest_r} * {{VALUE_W{1'b0}}, RECIP_TEN};
    quot = VALUE_W'(prod >> RECIP_SHIFT);
    rem  = DIGIT_W'(rest_r[DIGIT_W-1:0] - DIGIT_W'(quot[DIGIT_W-1:0] * 4'd10));
  end

  always_comb begin
    cell_out.valid = valid_r;
    cell_out.rest  = hex_r ? (rest_r >> DIGIT_W) : quot;
    cell_out.hex   = hex_r;
    cell_out.pos   = POS_W'(pos_r - 1'b1);
    emit.valid     = valid_r;
    emit.digit     = hex_r ? rest_r[DIGIT_W-1:0] : rem;
    emit.pos       = pos_r;
  end

endmodule
